FILE: src/bpes_pkg.sv
// Package for the bit-parallel edit score block.
// Holds the command codes and the payload types shared by the interfaces and the top level.
// No dependencies.
`timescale 1ns / 1ps

package bpes_pkg;

    localparam int CMD_W    = 2;
    localparam int SYMBOL_W = 8;
    localparam int SCORE_W  = 17;

    typedef logic [CMD_W-1:0]           cmd_t;
    typedef logic [SYMBOL_W-1:0]        symbol_t;
    typedef logic signed [SCORE_W-1:0]  score_t;

    localparam cmd_t CMD_PATTERN = 2'd0;
    localparam cmd_t CMD_TEXT    = 2'd1;
    localparam cmd_t CMD_FINISH  = 2'd2;

    // Width of one group in the population count of the finish path.
    localparam int GRP_BITS = 8;
    localparam int GRP_CW   = 4;

endpackage

FILE: src/bpes_if.sv
// Valid/ready channel interfaces for the bit-parallel edit score block.
// bpes_item_if carries input beats, bpes_result_if carries result beats.
// Depends on bpes_pkg.
`timescale 1ns / 1ps

interface bpes_item_if
    import bpes_pkg::*;
();
    logic    valid;
    logic    ready;
    cmd_t    cmd;
    symbol_t symbol;

    modport source (output valid, output cmd, output symbol, input ready);
    modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

interface bpes_result_if
    import bpes_pkg::*;
();
    logic   valid;
    logic   ready;
    score_t score;
    logic   error;

    modport source (output valid, output score, output error, input ready);
    modport sink   (input valid, input score, input error, output ready);
endinterface

FILE: src/bit_parallel_edit_score.sv
// Top level of the bit-parallel edit score block.
// Holds the input register, the three-vector recurrence and the pipelined finish path.
// Depends on bpes_pkg and the channel interfaces in bpes_if.sv.
`timescale 1ns / 1ps

// Scores a pattern string against a text string as the negated edit distance
// (match 0, mismatch and gap -1). Send up to PATTERN_MAX pattern beats first, then up to
// TEXT_MAX text beats, then one finish beat; the finish beat alone produces a result beat,
// which carries the score and an error flag that is set if any byte was dropped (too many
// pattern bytes, too many text bytes, or a pattern byte after text). The finish beat also
// clears the run, so the next string pair may follow at once. The block takes one beat in
// every cycle while no finish beat waits on a full finish path: each beat is held in the
// input register and updates the state from there, the limit being the carry chain of the
// PATTERN_MAX-bit add in the text update. A result beat passes from the input register
// through a snapshot stage, a stage of grouped bit counts and the output register. Results
// already waiting stop input beats only when a finish beat sits in the input register while
// the whole finish path is full; pattern and text beats keep flowing otherwise. There is no
// clearing pass after reset.
module bit_parallel_edit_score
    import bpes_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int TEXT_MAX    = 65535
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    bpes_item_if.sink            items,
    bpes_result_if.source        results
);

    localparam int W      = PATTERN_MAX;
    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TXT_W  = $clog2(TEXT_MAX + 1);
    localparam int GRP_N  = (PATTERN_MAX + GRP_BITS - 1) / GRP_BITS;
    localparam int PAD_W  = GRP_N * GRP_BITS;

    // ------------------------------------------------------------------
    // Handshake of the four stages. Every stage moves on when the stage
    // after it is empty or moving; only finish beats enter the finish path,
    // so pattern and text beats never wait for a stalled result.
    // ------------------------------------------------------------------
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    cmd_t    s0_cmd_reg;
    symbol_t s0_symbol_reg;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s0_finish;
    logic s0_go;
    logic s0_free;

    assign out_free  = !out_valid_reg || results.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign s0_finish = (s0_cmd_reg == CMD_FINISH);
    assign s0_go     = s0_valid_reg && (!s0_finish || s1_free);
    assign s0_free   = !s0_valid_reg || s0_go;

    assign items.ready = s0_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_free)
        begin
            s0_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && s0_free)
        begin
            s0_cmd_reg    <= items.cmd;
            s0_symbol_reg <= items.symbol;
        end
    end

    // ------------------------------------------------------------------
    // Run state. The pattern store is a row of byte registers, each compared
    // with the text byte at its own column; columns at or above the pattern
    // count are masked, so stale bytes never matter and need no reset.
    // ------------------------------------------------------------------
    symbol_t            pattern_reg [PATTERN_MAX];
    logic [CNT_W-1:0]   pat_count_reg;
    logic [CNT_W-1:0]   pat_count_next;
    logic [TXT_W-1:0]   text_count_reg;
    logic [TXT_W-1:0]   text_count_next;
    logic [W-1:0]       hz_reg;
    logic [W-1:0]       hz_next;
    logic [W-1:0]       hp_reg;
    logic [W-1:0]       hp_next;
    logic               error_seen_reg;
    logic               error_seen_next;
    logic               pat_write;

    logic [W-1:0] col_mask;
    logic [W-1:0] eq;
    logic [W-1:0] h_neg;
    logic [W-1:0] seed;
    logic [W-1:0] v_plus;
    logic [W-1:0] vpe;
    logic [W-1:0] v_zero;
    logic [W-1:0] v_neg;
    logic [W-1:0] hpe;
    logic [W-1:0] h_rest;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            col_mask[i] = (CNT_W'(i) < pat_count_reg);
            eq[i]       = col_mask[i] && (pattern_reg[i] == s0_symbol_reg);
        end
    end

    // Three-vector recurrence. Horizontal differences are coded as zero
    // (hz), plus one (hp) or, with neither bit set, minus one. The add
    // carries only upwards, so columns above the pattern never disturb
    // the columns below.
    always_comb
    begin
        h_neg  = ~(hz_reg | hp_reg);
        seed   = h_neg & eq;
        v_plus = ((seed + h_neg) ^ h_neg) ^ seed;
        vpe    = v_plus | eq;
        v_zero = ((hz_reg & vpe) | (h_neg & ~vpe)) << 1;
        v_neg  = ~(v_plus | v_zero);
        hpe    = hp_reg | eq;
        h_rest = ~hpe;
    end

    always_comb
    begin
        pat_count_next  = pat_count_reg;
        text_count_next = text_count_reg;
        hz_next         = hz_reg;
        hp_next         = hp_reg;
        error_seen_next = error_seen_reg;
        pat_write       = 1'b0;
        if (s0_go)
        begin
            unique case (s0_cmd_reg)
                CMD_PATTERN:
                begin
                    if ((text_count_reg != '0) || (pat_count_reg >= CNT_W'(PATTERN_MAX)))
                    begin
                        error_seen_next = 1'b1;
                    end
                    else
                    begin
                        pat_write      = 1'b1;
                        pat_count_next = pat_count_reg + CNT_W'(1);
                    end
                end
                CMD_TEXT:
                begin
                    if (text_count_reg >= TXT_W'(TEXT_MAX))
                    begin
                        error_seen_next = 1'b1;
                    end
                    else
                    begin
                        hz_next         = (v_zero & hpe) | (v_neg & h_rest);
                        hp_next         = v_neg & hpe;
                        text_count_next = text_count_reg + TXT_W'(1);
                    end
                end
                CMD_FINISH:
                begin
                    pat_count_next  = '0;
                    text_count_next = '0;
                    hz_next         = '0;
                    hp_next         = '0;
                    error_seen_next = 1'b0;
                end
                default:
                begin
                    // The unused command code changes nothing.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_count_reg  <= '0;
            text_count_reg <= '0;
            hz_reg         <= '0;
            hp_reg         <= '0;
            error_seen_reg <= 1'b0;
        end
        else
        begin
            pat_count_reg  <= pat_count_next;
            text_count_reg <= text_count_next;
            hz_reg         <= hz_next;
            hp_reg         <= hp_next;
            error_seen_reg <= error_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_write)
        begin
            pattern_reg[pat_count_reg[IDX_W-1:0]] <= s0_symbol_reg;
        end
    end

    // ------------------------------------------------------------------
    // Finish path. The snapshot stage keeps the masked difference vectors
    // and the constant part of the score, -(text count + pattern count);
    // each zero column then adds one and each plus column adds two.
    // ------------------------------------------------------------------
    logic [W-1:0]    s1_z_reg;
    logic [W-1:0]    s1_p_reg;
    score_t          s1_base_reg;
    logic            s1_error_reg;

    logic [GRP_CW-1:0] s2_zc_reg [GRP_N];
    logic [GRP_CW-1:0] s2_pc_reg [GRP_N];
    score_t            s2_base_reg;
    logic              s2_error_reg;

    score_t out_score_reg;
    logic   out_error_reg;

    logic [PAD_W-1:0]  z_pad;
    logic [PAD_W-1:0]  p_pad;
    logic [GRP_CW-1:0] zc_grp [GRP_N];
    logic [GRP_CW-1:0] pc_grp [GRP_N];
    logic [CNT_W-1:0]  z_sum;
    logic [CNT_W-1:0]  p_sum;
    score_t            score_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s0_go && s0_finish;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_comb
    begin
        z_pad = PAD_W'(s1_z_reg);
        p_pad = PAD_W'(s1_p_reg);
        for (int g = 0; g < GRP_N; g++)
        begin
            zc_grp[g] = '0;
            pc_grp[g] = '0;
            for (int b = 0; b < GRP_BITS; b++)
            begin
                zc_grp[g] = zc_grp[g] + GRP_CW'(z_pad[g * GRP_BITS + b]);
                pc_grp[g] = pc_grp[g] + GRP_CW'(p_pad[g * GRP_BITS + b]);
            end
        end
    end

    always_comb
    begin
        z_sum = '0;
        p_sum = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            z_sum = z_sum + CNT_W'(s2_zc_reg[g]);
            p_sum = p_sum + CNT_W'(s2_pc_reg[g]);
        end
        score_sum = s2_base_reg + SCORE_W'(z_sum) + (SCORE_W'(p_sum) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (s0_go && s0_finish && s1_free)
        begin
            s1_z_reg     <= hz_reg & col_mask;
            s1_p_reg     <= hp_reg & col_mask;
            s1_base_reg  <= -(SCORE_W'(text_count_reg) + SCORE_W'(pat_count_reg));
            s1_error_reg <= error_seen_reg;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_zc_reg    <= zc_grp;
            s2_pc_reg    <= pc_grp;
            s2_base_reg  <= s1_base_reg;
            s2_error_reg <= s1_error_reg;
        end
        if (s2_valid_reg && out_free)
        begin
            out_score_reg <= score_sum;
            out_error_reg <= s2_error_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.score = out_score_reg;
    assign results.error = out_error_reg;

    // ------------------------------------------------------------------
    // Checks on the block's own logic.
    // ------------------------------------------------------------------

    // A column can never be both zero and plus at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hz_reg & hp_reg) == '0)
    else $error("difference vectors overlap");

    // A finish beat leaves a cleared run behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s0_go && s0_finish) |=> (pat_count_reg == '0) && (text_count_reg == '0)
                                 && !error_seen_reg && (hz_reg == '0) && (hp_reg == '0))
    else $error("run not cleared after finish");

    // Once text has been taken, no further pattern byte is stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_count_reg != '0) |-> !pat_write)
    else $error("pattern byte stored after text");

    // Input is refused only while the input register holds a finish beat
    // that the full finish path cannot take.
    assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> (s0_valid_reg && s0_finish && s1_valid_reg && s2_valid_reg
                          && out_valid_reg))
    else $error("input refused without a full finish path");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bit-parallel edit score block.
// Drives pattern, text and finish beats and checks every score beat against its own model.
// Depends on bpes_pkg, the channel interfaces in bpes_if.sv and bit_parallel_edit_score.
`timescale 1ns / 1ps

module testbench;
    import bpes_pkg::*;

    // Sizes that the block is built with here; the predictor uses the same limits.
    localparam int PATTERN_LIMIT = 64;
    localparam int TEXT_LIMIT    = 65535;

    // The fourth command code is not used by the block and must be ignored.
    localparam cmd_t CMD_UNUSED = 2'd3;

    // Number of input beats, cmd 3 excluded, at which each random phase stops.
    localparam int PHASE_ONE_END   = 583;
    localparam int PHASE_TWO_END   = 1166;
    localparam int PHASE_THREE_END = 1750;

    // Cycles allowed after the last expected score beat has come out.
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        score_t score;
        logic   error;
    } score_result_t;

    // One row of the directed table. Where typed is set, the expected score beat is the one
    // written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        cmd_t    cmd;
        symbol_t symbol;
        bit      typed;
        score_t  score;
        logic    error;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 19;
    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // A finish straight after reset scores two empty strings.
        '{CMD_FINISH,  8'h00, 1'b1, 17'sd0,  1'b0},
        // Extreme byte values on both strings.
        '{CMD_PATTERN, 8'h00, 1'b0, 17'sd0,  1'b0},
        '{CMD_PATTERN, 8'hFF, 1'b0, 17'sd0,  1'b0},
        '{CMD_TEXT,    8'hFF, 1'b0, 17'sd0,  1'b0},
        '{CMD_TEXT,    8'h00, 1'b0, 17'sd0,  1'b0},
        '{CMD_FINISH,  8'h00, 1'b0, 17'sd0,  1'b0},
        // Empty pattern: the score is minus the text length.
        '{CMD_TEXT,    8'h5A, 1'b0, 17'sd0,  1'b0},
        '{CMD_TEXT,    8'hA5, 1'b0, 17'sd0,  1'b0},
        '{CMD_FINISH,  8'hFF, 1'b1, -17'sd2, 1'b0},
        // Empty text: the score is minus the pattern length.
        '{CMD_PATTERN, 8'h41, 1'b0, 17'sd0,  1'b0},
        '{CMD_PATTERN, 8'h42, 1'b0, 17'sd0,  1'b0},
        '{CMD_PATTERN, 8'h43, 1'b0, 17'sd0,  1'b0},
        '{CMD_FINISH,  8'h00, 1'b1, -17'sd3, 1'b0},
        // A pattern byte after text is dropped and flags the run.
        '{CMD_PATTERN, 8'h11, 1'b0, 17'sd0,  1'b0},
        '{CMD_TEXT,    8'h11, 1'b0, 17'sd0,  1'b0},
        '{CMD_PATTERN, 8'h22, 1'b0, 17'sd0,  1'b0},
        '{CMD_FINISH,  8'h00, 1'b1, 17'sd0,  1'b1},
        // The unused command changes nothing, and the flag was cleared by the last finish.
        '{CMD_UNUSED,  8'hFF, 1'b0, 17'sd0,  1'b0},
        '{CMD_FINISH,  8'h00, 1'b1, 17'sd0,  1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    bpes_item_if   items_ch();
    bpes_result_if results_ch();

    bit_parallel_edit_score #(
        .PATTERN_MAX (PATTERN_LIMIT),
        .TEXT_MAX    (TEXT_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle rates in percent, changed by the stimulus process from phase to phase.
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 62;

    int fails      = 0;
    int beats_sent = 0;

    // Score beats that the model says are still to come, oldest first.
    score_result_t pending_scores[$];

    // The model's own copy of the block's state.
    symbol_t     model_pattern [PATTERN_LIMIT];
    int          model_pattern_len;
    int          model_text_len;
    logic [63:0] model_horiz_zero;
    logic [63:0] model_horiz_plus;
    bit          model_dropped;

    // Alphabet for the string pair under construction. A narrow alphabet makes matches common,
    // which is what drives the recurrence through its interesting carries.
    symbol_t     run_alphabet [4];
    int unsigned run_alphabet_len;
    bit          run_narrow;

    function automatic void clear_model();
        model_pattern_len = 0;
        model_text_len    = 0;
        model_horiz_zero  = '0;
        model_horiz_plus  = '0;
        model_dropped     = 1'b0;
    endfunction

    // One step of the three-vector recurrence for a kept text byte. The horizontal vectors
    // hold +1 where horiz_plus is set, 0 where horiz_zero is set and -1 elsewhere.
    function automatic void advance_text_column(symbol_t sym);
        logic [63:0] eq;
        logic [63:0] h_neg;
        logic [63:0] seed;
        logic [63:0] v_plus;
        logic [63:0] v_plus_eq;
        logic [63:0] v_zero;
        logic [63:0] v_neg;
        logic [63:0] h_plus_eq;
        eq = '0;
        for (int i = 0; i < model_pattern_len; i++)
        begin
            if (model_pattern[i] == sym)
                eq[i] = 1'b1;
        end
        h_neg     = ~(model_horiz_zero | model_horiz_plus);
        seed      = h_neg & eq;
        v_plus    = ((seed + h_neg) ^ h_neg) ^ seed;
        v_plus_eq = v_plus | eq;
        v_zero    = ((model_horiz_zero & v_plus_eq) | (h_neg & ~v_plus_eq)) << 1;
        v_neg     = ~(v_plus | v_zero);
        h_plus_eq = model_horiz_plus | eq;
        model_horiz_zero = (v_zero & h_plus_eq) | (v_neg & ~h_plus_eq);
        model_horiz_plus = v_neg & h_plus_eq;
    endfunction

    // Applies one accepted beat to the model and, on a finish, queues the score beat.
    // A typed expectation from the directed table replaces the computed one.
    function automatic void predict_edit_score(cmd_t cmd, symbol_t sym, bit typed,
                                               score_t typed_score, logic typed_error);
        score_result_t res;
        int            acc;
        case (cmd)
            CMD_PATTERN:
            begin
                if (model_text_len != 0 || model_pattern_len >= PATTERN_LIMIT)
                    model_dropped = 1'b1;
                else
                begin
                    model_pattern[model_pattern_len] = sym;
                    model_pattern_len++;
                end
            end
            CMD_TEXT:
            begin
                if (model_text_len >= TEXT_LIMIT)
                    model_dropped = 1'b1;
                else
                begin
                    advance_text_column(sym);
                    model_text_len++;
                end
            end
            CMD_FINISH:
            begin
                acc = -model_text_len;
                for (int i = 0; i < model_pattern_len; i++)
                    acc += int'(model_horiz_zero[i]) + 2 * int'(model_horiz_plus[i]) - 1;
                res.score = score_t'(acc);
                res.error = model_dropped;
                if (typed)
                begin
                    res.score = typed_score;
                    res.error = typed_error;
                end
                pending_scores.push_back(res);
                clear_model();
            end
            default:
            begin
                // The unused command leaves the state alone.
            end
        endcase
    endfunction

    function automatic symbol_t pick_symbol();
        if (run_narrow)
            return run_alphabet[$urandom_range(run_alphabet_len - 1, 0)];
        return symbol_t'($urandom_range(255, 0));
    endfunction

    // Presents one beat and holds it until the block takes it. Valid stays high into the next
    // beat unless an idle gap is drawn, so it is never lowered and raised in the same step.
    task automatic send_beat(input cmd_t cmd, input symbol_t sym, input bit typed = 1'b0,
                             input score_t typed_score = '0, input logic typed_error = 1'b0);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid  <= 1'b1;
        items_ch.cmd    <= cmd;
        items_ch.symbol <= sym;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        predict_edit_score(cmd, sym, typed, typed_score, typed_error);
        if (cmd != CMD_UNUSED)
            beats_sent++;
    endtask

    // Holds the sender back until every score beat owed so far has come out.
    task automatic wait_for_scores();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // One random string pair closed by a finish. Most pairs are short and well formed; a few
    // fill the pattern, overflow it, place a pattern byte after text, or carry an unused beat.
    task automatic random_string_pair();
        int unsigned sel;
        int          pattern_len;
        int          text_len;
        int          late_after;
        int          noise_at;
        run_narrow       = ($urandom_range(99, 0) < 70);
        run_alphabet_len = $urandom_range(4, 1);
        foreach (run_alphabet[k])
            run_alphabet[k] = symbol_t'($urandom_range(255, 0));
        sel = $urandom_range(99, 0);
        if (sel < 85)
            pattern_len = $urandom_range(12, 0);
        else if (sel < 97)
            pattern_len = $urandom_range(64, 13);
        else
            pattern_len = $urandom_range(67, 65);
        text_len = ($urandom_range(99, 0) < 85) ? $urandom_range(16, 0) : $urandom_range(80, 17);
        late_after = -1;
        if (text_len > 0 && $urandom_range(99, 0) < 5)
            late_after = $urandom_range(text_len, 1);
        noise_at = -1;
        if ($urandom_range(99, 0) < 8)
            noise_at = $urandom_range(pattern_len + text_len, 0);

        for (int i = 0; i < pattern_len; i++)
        begin
            if (i == noise_at)
                send_beat(CMD_UNUSED, symbol_t'($urandom_range(255, 0)));
            send_beat(CMD_PATTERN, pick_symbol());
        end
        for (int j = 0; j < text_len; j++)
        begin
            if (pattern_len + j == noise_at)
                send_beat(CMD_UNUSED, symbol_t'($urandom_range(255, 0)));
            send_beat(CMD_TEXT, pick_symbol());
            if (j + 1 == late_after)
                send_beat(CMD_PATTERN, pick_symbol());
        end
        if (pattern_len + text_len == noise_at)
            send_beat(CMD_UNUSED, symbol_t'($urandom_range(255, 0)));
        send_beat(CMD_FINISH, symbol_t'($urandom_range(255, 0)));
    endtask

    // Compares a score beat with the oldest one the model owes.
    function automatic void check_score_beat(score_t score, logic error);
        score_result_t exp;
        if (pending_scores.size() == 0)
        begin
            $error("score beat with none pending: score %0d error %0b", score, error);
            fails++;
            return;
        end
        exp = pending_scores.pop_front();
        if (score !== exp.score)
        begin
            $error("score: expected %0d, actual %0d", exp.score, score);
            fails++;
        end
        if (error !== exp.error)
        begin
            $error("error: expected %0b, actual %0b", exp.error, error);
            fails++;
        end
    endfunction

    // Receiver: samples the result channel at each rising edge, before the block's own
    // updates of that edge, then draws ready for the next cycle.
    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_ch.valid && results_ch.ready)
                check_score_beat(results_ch.score, results_ch.error);
            results_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Stimulus: reset, the directed table, the full-pattern case, and three random phases
    // with different idle rates on each side.
    initial
    begin
        rst_n           = 1'b0;
        items_ch.valid  = 1'b0;
        items_ch.cmd    = CMD_PATTERN;
        items_ch.symbol = '0;
        clear_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: the sender idles a little, the receiver a lot.
        send_idle_pct = 19;
        recv_idle_pct = 62;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_beat(DIRECTED_TABLE[r].cmd, DIRECTED_TABLE[r].symbol, DIRECTED_TABLE[r].typed,
                      DIRECTED_TABLE[r].score, DIRECTED_TABLE[r].error);

        // A full pattern of one byte, one byte too many, and a matching text of full length:
        // the score is zero, but the dropped byte raises the flag.
        for (int n = 0; n <= PATTERN_LIMIT; n++)
            send_beat(CMD_PATTERN, 8'h41);
        for (int n = 0; n < PATTERN_LIMIT; n++)
            send_beat(CMD_TEXT, 8'h41);
        send_beat(CMD_FINISH, 8'h00, 1'b1, 17'sd0, 1'b1);

        while (beats_sent < PHASE_ONE_END)
            random_string_pair();
        wait_for_scores();

        // Phase two: the roles of the two sides are swapped.
        send_idle_pct = 62;
        recv_idle_pct = 19;
        while (beats_sent < PHASE_TWO_END)
            random_string_pair();
        wait_for_scores();

        // Phase three: neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (beats_sent < PHASE_THREE_END)
            random_string_pair();

        items_ch.valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("[bit_parallel_edit_score] OK");
        else
            $display("[bit_parallel_edit_score] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run under the heaviest idling.
    initial
    begin
        #4_000_000;
        $display("[bit_parallel_edit_score] ERROR");
        $finish;
    end

endmodule
